// ----- design/ptdbb_pkg.sv -----
// Shared types, codes and the sine/cosine table builder for the pulse timing DFT band bank.
package ptdbb_pkg;

  // Event kinds carried by an input word.
  typedef enum logic [1:0] {
    KIND_SET_EDGE   = 2'd0,
    KIND_RESET_EDGE = 2'd1,
    KIND_READ       = 2'd2,
    KIND_RESTART    = 2'd3
  } kind_t;

  // Configuration register indexes.
  localparam logic [1:0] REG_ROOT_STEP    = 2'd0;
  localparam logic [1:0] REG_BAND_SPACING = 2'd1;
  localparam logic [1:0] REG_HALF_SPAN    = 2'd2;

  localparam int CORDIC_STEPS = 16;
  localparam longint CORDIC_GAIN_Q30 = 64'sd652032874;
  localparam longint ATAN_TURNS [CORDIC_STEPS] = '{
    536870912, 316933406, 167458907, 85004756, 42667334, 21354465,
    10679838, 5340247, 2670163, 1335087, 667544, 333772, 166886, 83443,
    41722, 20861
  };

  // Rounds a Q30 value half up to Q1.14 and clips it to plus or minus one.
  function automatic longint to_q14(input longint v);
    longint r;
    r = (v + 64'sd32768) >>> 16;
    if (r > 64'sd16384) r = 64'sd16384;
    if (r < -64'sd16384) r = -64'sd16384;
    return r;
  endfunction

  // Elaboration-time CORDIC rotation of a first-quadrant angle (turns scaled
  // by 2^32). Returns {cos, sin}, each a signed 16-bit Q1.14 value.
  function automatic logic [31:0] cordic_entry(input logic [31:0] ang);
    longint x;
    longint y;
    longint z;
    longint dx;
    longint dy;
    longint cq;
    longint sq;
    x = CORDIC_GAIN_Q30;
    y = 0;
    z = longint'(ang & 32'h3FFF_FFFF);
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - ATAN_TURNS[i];
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + ATAN_TURNS[i];
      end
    end
    cq = to_q14(x);
    sq = to_q14(y);
    return {cq[15:0], sq[15:0]};
  endfunction

endpackage

// ----- design/ptdbb_if.sv -----
// Valid/ready channel interfaces for pulse event words and band score words.
interface ptdbb_pulse_if
  import ptdbb_pkg::*;
();
  logic        valid;
  logic        ready;
  kind_t       kind;
  logic [15:0] length;

  modport source (output valid, output kind, output length, input ready);
  modport sink (input valid, input kind, input length, output ready);
endinterface

interface ptdbb_score_if;
  logic        valid;
  logic        ready;
  logic [3:0]  band_index;
  logic [31:0] score;
  logic        last;

  modport source (output valid, output band_index, output score, output last, input ready);
  modport sink (input valid, input band_index, input score, input last, output ready);
endinterface

// ----- design/pulse_timing_dft_band_bank.sv -----
// Top level of the pulse timing DFT band bank: sequencer, band store, multiplier and sine table.
//
// This block is a bank of 2*half_span+1 single-bin DFT filters fed by pulse-length events.
// Each band keeps a 32-bit phase (a fraction of a turn that wraps) and saturating signed
// real and imaginary sums. A set-edge or reset-edge word advances every band's phase by
// length times its step, where band i steps by root_step + (i - half_span) * band_spacing;
// a set-edge word also adds the cosine and sine of the new phase (Q1.14, taken from a
// quarter-wave table of 2^(SINE_TABLE_BITS-2) entries) into the sums. A read word returns
// one score per band, lowest band first, equal to (re^2 + im^2) >> 28 saturated to 32 bits,
// with last set on the final band. A restart word clears all phases and sums.
// half_span above MAX_HALF_SPAN acts as MAX_HALF_SPAN. Configuration writes do not touch
// the phases or sums and must only be made while the bank is idle.
// The bands are visited one at a time by a small sequencer that shares a single 32x32
// multiplier, one read/write port into the band store, and the sine table. Each band of an
// edge word goes through the multiplier stage and the registered store read, and a set-edge
// word also through the registered table read; the active band count is at most 9 by default.
// A read word waits on each band's score while the consumer holds the score output off. The
// input is not ready while a word is being worked on; the score output is registered, so the
// next word can be accepted while the last score still waits.
module pulse_timing_dft_band_bank
  import ptdbb_pkg::*;
#(
  parameter int MAX_HALF_SPAN   = 4,
  parameter int SINE_TABLE_BITS = 10
) (
  input  logic               clk,
  input  logic               rst,
  ptdbb_pulse_if.sink        pulses,
  ptdbb_score_if.source      scores,
  input  logic               wr_en,
  input  logic [1:0]         wr_index,
  input  logic [31:0]        wr_data
);

  localparam int SLOTS  = 2 * MAX_HALF_SPAN + 1;
  localparam int IW     = $clog2(2 * MAX_HALF_SPAN + 2);
  localparam int HSW    = $clog2(MAX_HALF_SPAN + 2);
  localparam int QBITS  = SINE_TABLE_BITS - 2;
  localparam int QDEPTH = 1 << QBITS;

  typedef struct packed {
    logic [31:0]        phase;
    logic signed [31:0] re;
    logic signed [31:0] im;
  } entry_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCALE,
    S_BASE,
    S_ADV_RD,
    S_ADV_SUM,
    S_ROM,
    S_ACC,
    S_RD_RD,
    S_RD_ABS,
    S_RD_MRE,
    S_RD_MIM,
    S_RD_OUT
  } state_t;

  // Configuration registers.
  logic [31:0]        root_step;
  logic signed [31:0] band_spacing;
  logic [2:0]         half_span;

  // Sequencer state.
  state_t          state;
  kind_t           kind;
  logic [15:0]     length;
  logic [HSW-1:0]  hs_act;
  logic [IW-1:0]   last_idx;
  logic [IW-1:0]   idx;
  logic [31:0]     step;
  entry_t          cur;
  logic [31:0]     mag_re;
  logic [31:0]     mag_im;
  logic [63:0]     sq_re;
  logic [SLOTS-1:0] filled;

  // Shared multiplier with a registered product.
  logic [31:0] op_a;
  logic [31:0] op_b;
  logic [63:0] prod;

  // Band store: one write and one registered read per cycle.
  entry_t mem [SLOTS];
  entry_t rd_entry;
  logic   mem_we;
  entry_t mem_wdata;

  // Quarter-wave table of {cos, sin} pairs.
  logic [31:0]      sincos_rom [QDEPTH];
  logic [31:0]      rom_q;
  logic [QBITS-1:0] rom_addr;

  // Score output register.
  logic        out_valid;
  logic [3:0]  out_band;
  logic [31:0] out_score;
  logic        out_last;

  // Datapath helpers.
  logic [HSW-1:0]     hs_clip;
  logic [31:0]        phase_new;
  logic signed [15:0] cq;
  logic signed [15:0] sq;
  logic signed [15:0] cos_v;
  logic signed [15:0] sin_v;
  logic [63:0]        total;
  logic [31:0]        score_sat;
  logic               out_free;
  logic               band_done;

  for (genvar g = 0; g < QDEPTH; g++) begin : g_rom
    localparam logic [31:0] ENTRY = cordic_entry(32'(g) << (32 - SINE_TABLE_BITS));
    assign sincos_rom[g] = ENTRY;
  end

  function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                 input logic signed [15:0] b);
    logic signed [32:0] s;
    s = {a[31], a} + {{17{b[15]}}, b};
    if (s[32] != s[31]) begin
      return s[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end
    return s[31:0];
  endfunction

  function automatic logic [31:0] abs32(input logic signed [31:0] v);
    return v[31] ? (~v + 32'd1) : v;
  endfunction

  assign hs_clip = (32'(half_span) > 32'(MAX_HALF_SPAN)) ? HSW'(MAX_HALF_SPAN)
                                                       : HSW'(half_span);

  always_comb begin
    case (state)
      S_SCALE: begin
        op_a = band_spacing;
        op_b = 32'(hs_act);
      end
      S_ADV_RD: begin
        op_a = step;
        op_b = 32'(length);
      end
      S_RD_MRE: begin
        op_a = mag_re;
        op_b = mag_re;
      end
      default: begin
        op_a = mag_im;
        op_b = mag_im;
      end
    endcase
  end

  // Quadrant mapping of the first-quadrant table value.
  assign rom_addr = cur.phase[29 -: QBITS];
  assign cq       = rom_q[31:16];
  assign sq       = rom_q[15:0];

  always_comb begin
    case (cur.phase[31:30])
      2'd0: begin
        cos_v = cq;
        sin_v = sq;
      end
      2'd1: begin
        cos_v = -sq;
        sin_v = cq;
      end
      2'd2: begin
        cos_v = -cq;
        sin_v = -sq;
      end
      default: begin
        cos_v = sq;
        sin_v = -cq;
      end
    endcase
  end

  assign phase_new = rd_entry.phase + prod[31:0];

  always_comb begin
    mem_we    = 1'b0;
    mem_wdata = cur;
    case (state)
      S_ADV_SUM: begin
        mem_we    = (kind == KIND_RESET_EDGE);
        mem_wdata = '{phase: phase_new, re: rd_entry.re, im: rd_entry.im};
      end
      S_ACC: begin
        mem_we    = 1'b1;
        mem_wdata = '{phase: cur.phase, re: sat_add(cur.re, cos_v), im: sat_add(cur.im, sin_v)};
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  assign total     = sq_re + prod;
  assign score_sat = (total[63:60] != 4'd0) ? 32'hFFFF_FFFF : total[59:28];
  assign out_free  = !out_valid || scores.ready;
  assign band_done = (idx == last_idx);

  always_ff @(posedge clk) begin
    prod  <= op_a * op_b;
    rom_q <= sincos_rom[rom_addr];
    rd_entry <= filled[idx] ? mem[idx] : '0;
    if (mem_we) begin
      mem[idx] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      root_step    <= '0;
      band_spacing <= '0;
      half_span    <= '0;
    end else if (wr_en) begin
      case (wr_index)
        REG_ROOT_STEP:    root_step    <= wr_data;
        REG_BAND_SPACING: band_spacing <= wr_data;
        REG_HALF_SPAN:    half_span    <= wr_data[2:0];
        default:          ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      filled    <= '0;
      out_valid <= 1'b0;
      idx       <= '0;
    end else begin
      // A taken score empties the register unless the sequencer refills it in the same cycle.
      if (out_valid && scores.ready && state != S_RD_OUT) begin
        out_valid <= 1'b0;
      end
      if (mem_we) begin
        filled[idx] <= 1'b1;
      end
      case (state)
        S_IDLE: begin
          if (pulses.valid) begin
            kind     <= pulses.kind;
            length   <= pulses.length;
            hs_act   <= hs_clip;
            last_idx <= IW'({hs_clip, 1'b0});
            idx      <= '0;
            case (pulses.kind)
              KIND_RESTART: filled <= '0;
              KIND_READ:    state  <= S_RD_RD;
              default:      state  <= S_SCALE;
            endcase
          end
        end
        S_SCALE: begin
          state <= S_BASE;
        end
        S_BASE: begin
          step  <= root_step - prod[31:0];
          state <= S_ADV_RD;
        end
        S_ADV_RD: begin
          state <= S_ADV_SUM;
        end
        S_ADV_SUM: begin
          cur <= '{phase: phase_new, re: rd_entry.re, im: rd_entry.im};
          if (kind == KIND_SET_EDGE) begin
            state <= S_ROM;
          end else if (band_done) begin
            state <= S_IDLE;
          end else begin
            idx   <= idx + IW'(1);
            step  <= step + band_spacing;
            state <= S_ADV_RD;
          end
        end
        S_ROM: begin
          state <= S_ACC;
        end
        S_ACC: begin
          if (band_done) begin
            state <= S_IDLE;
          end else begin
            idx   <= idx + IW'(1);
            step  <= step + band_spacing;
            state <= S_ADV_RD;
          end
        end
        S_RD_RD: begin
          state <= S_RD_ABS;
        end
        S_RD_ABS: begin
          mag_re <= abs32(rd_entry.re);
          mag_im <= abs32(rd_entry.im);
          state  <= S_RD_MRE;
        end
        S_RD_MRE: begin
          state <= S_RD_MIM;
        end
        S_RD_MIM: begin
          sq_re <= prod;
          state <= S_RD_OUT;
        end
        S_RD_OUT: begin
          if (out_free) begin
            out_valid <= 1'b1;
            out_band  <= 4'(idx);
            out_score <= score_sat;
            out_last  <= band_done;
            if (band_done) begin
              state <= S_IDLE;
            end else begin
              idx   <= idx + IW'(1);
              state <= S_RD_RD;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign pulses.ready      = (state == S_IDLE);
  assign scores.valid      = out_valid;
  assign scores.band_index = out_band;
  assign scores.score      = out_score;
  assign scores.last       = out_last;

endmodule

// ----- design/ptdbb_checker.sv -----
// Port-level checker for the pulse timing DFT band bank and its bind statement.
module ptdbb_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [3:0]  band_index,
  input logic [31:0] score,
  input logic        last
);

  // A held score word keeps its payload.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(band_index) && $stable(score)
                                && $stable(last))
    else $error("score word changed while stalled");

  // The last band of a read is twice the active half span, so its index is even.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && last |-> !band_index[0])
    else $error("last score word on an odd band");

  // While a read still has bands to deliver, no new event is taken.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last |-> !in_ready)
    else $error("input ready in the middle of a read");

  // Reset empties the score register and leaves the bank ready for an event.
  assert property (@(posedge clk) rst |=> !out_valid && in_ready)
    else $error("bank not idle after reset");

  // An offered event word stays offered until the bank takes it.
  assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |=> in_valid)
    else $error("event word withdrawn before it was taken");

endmodule

bind pulse_timing_dft_band_bank ptdbb_checker u_ptdbb_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (pulses.valid),
  .in_ready   (pulses.ready),
  .out_valid  (scores.valid),
  .out_ready  (scores.ready),
  .band_index (scores.band_index),
  .score      (scores.score),
  .last       (scores.last)
);

// ----- dv/testbench.sv -----
// Self-checking testbench for the pulse timing DFT band bank, with directed and random words.
module testbench;
  import ptdbb_pkg::*;

  // The bank is built with its default sizes, so the local copies below match it.
  localparam int MAX_HALF_SPAN = 4;
  localparam int SINE_TABLE_BITS = 10;
  localparam int BAND_SLOTS = 2 * MAX_HALF_SPAN + 1;
  localparam int ROTATION_STEPS = 16;
  localparam longint ROTATION_GAIN_Q30 = 64'sd652032874;

  // Arctangent of 2^-i for each rotation step, in turns scaled by 2^32.
  localparam longint ARC_STEP [ROTATION_STEPS] = '{
    536870912, 316933406, 167458907, 85004756, 42667334, 21354465,
    10679838, 5340247, 2670163, 1335087, 667544, 333772, 166886, 83443,
    41722, 20861
  };

  // Index 3 decodes to no register; writes there must leave the bank alone.
  localparam logic [1:0] REG_UNUSED = 2'd3;

  localparam int IDLE_PERCENT = 31;
  // The slowest word without a result is a set edge on nine bands; this pause covers any
  // work still under way once the last expected score has arrived.
  localparam int SETTLE_CYCLES = 64;
  localparam int RANDOM_PHASES = 6;
  localparam int WORDS_PER_PHASE = 80;
  // The random phase with no idling on either side.
  localparam int BUSY_PHASE = 2;
  // The limit covers about 500 words with output stalls and the register writes.
  localparam int CYCLE_LIMIT = 200_000;

  typedef struct packed {
    logic [3:0]  band_index;
    logic [31:0] score;
    logic        last;
  } band_score_t;

  typedef enum bit {
    ROW_WORD,
    ROW_CONFIG
  } row_kind_t;

  // One line of the directed plan: either a pulse word, optionally with its score typed in
  // for every band of a read, or a full set of register values.
  typedef struct packed {
    row_kind_t   what;
    kind_t       kind;
    logic [15:0] length;
    logic        known;
    logic [31:0] score;
    logic [31:0] root;
    logic [31:0] spacing;
    logic [31:0] span;
  } plan_row_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        wr_en;
  logic [1:0]  wr_index;
  logic [31:0] wr_data;

  ptdbb_pulse_if pulses ();
  ptdbb_score_if scores ();

  pulse_timing_dft_band_bank i_dut (
    .clk      (clk),
    .rst      (rst),
    .pulses   (pulses),
    .scores   (scores),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Expected behavior of the bank. Two-state storage starts at zero, which is the reset
  // state of both the registers and the band store.
  bit [31:0]        root_step_q;
  bit signed [31:0] spacing_q;
  bit [2:0]         span_q;
  bit [31:0]        phase_acc [BAND_SLOTS];
  int               re_acc [BAND_SLOTS];
  int               im_acc [BAND_SLOTS];

  band_score_t expected_scores [$];
  int          errors;
  int          idle_pct;

  // The directed plan. Scores are typed in only where they are obvious: zero right after
  // reset or a restart, and one after a single set edge at phase zero (cosine 16384 squared
  // is exactly 2^28). Everything else is left to the prediction.
  plan_row_t directed_plan [25] = '{
    // After reset: one band, all sums zero.
    '{ROW_WORD, KIND_READ, 16'd0, 1'b1, 32'd0, 32'd0, 32'd0, 32'd0},
    '{ROW_WORD, KIND_SET_EDGE, 16'd0, 1'b0, 32'd0, 32'd0, 32'd0, 32'd0},
    // The length of a read is ignored.
    '{ROW_WORD, KIND_READ, 16'hFFFF, 1'b1, 32'd1, 32'd0, 32'd0, 32'd0},
    '{ROW_WORD, KIND_RESTART, 16'hFFFF, 1'b0, 32'd0, 32'd0, 32'd0, 32'd0},
    '{ROW_WORD, KIND_READ, 16'd0, 1'b1, 32'd0, 32'd0, 32'd0, 32'd0},
    // Extreme steps; a half span of seven acts as the maximum of four.
    '{ROW_CONFIG, KIND_SET_EDGE, 16'd0, 1'b0, 32'd0, 32'hFFFF_FFFF, 32'h8000_0000,
      32'hFFFF_FFFF},
    '{ROW_WORD, KIND_SET_EDGE, 16'hFFFF, 1'b0, 32'd0, 32'd0, 32'd0, 32'd0},
    '{ROW_WORD, KIND_RESET_EDGE, 16'hFFFF, 1'b0, 32'd0, 32'd0, 32'd0, 32'd0},
    '{ROW_WORD, KIND_SET_EDGE, 16'h0001, 1'b0, 32'd0, 32'd0, 32'd0, 32'd0},
    '{ROW_WORD, KIND_READ, 16'd0, 1'b0, 32'd0, 32'd0, 32'd0, 32'd0},
    // New registers leave phases and sums as they were.
    '{ROW_CONFIG, KIND_SET_EDGE, 16'd0, 1'b0, 32'd0, 32'h8000_0000, 32'h7FFF_FFFF,
      32'd4},
    '{ROW_WORD, KIND_RESET_EDGE, 16'd0, 1'b0, 32'd0, 32'd0, 32'd0, 32'd0},
    '{ROW_WORD, KIND_SET_EDGE, 16'h8000, 1'b0, 32'd0, 32'd0, 32'd0, 32'd0},
    '{ROW_WORD, KIND_SET_EDGE, 16'h5555, 1'b0, 32'd0, 32'd0, 32'd0, 32'd0},
    '{ROW_WORD, KIND_READ, 16'hAAAA, 1'b0, 32'd0, 32'd0, 32'd0, 32'd0},
    // Negative spacing and a half span of five, which is also clipped to four.
    '{ROW_CONFIG, KIND_SET_EDGE, 16'd0, 1'b0, 32'd0, 32'h0123_4567, 32'hFFFF_FF00,
      32'd5},
    '{ROW_WORD, KIND_SET_EDGE, 16'h00FF, 1'b0, 32'd0, 32'd0, 32'd0, 32'd0},
    '{ROW_WORD, KIND_SET_EDGE, 16'hFF00, 1'b0, 32'd0, 32'd0, 32'd0, 32'd0},
    '{ROW_WORD, KIND_RESET_EDGE, 16'h7FFF, 1'b0, 32'd0, 32'd0, 32'd0, 32'd0},
    '{ROW_WORD, KIND_SET_EDGE, 16'h1234, 1'b0, 32'd0, 32'd0, 32'd0, 32'd0},
    '{ROW_WORD, KIND_READ, 16'd0, 1'b0, 32'd0, 32'd0, 32'd0, 32'd0},
    // Only the low three bits of the half span count; this leaves a single band.
    '{ROW_CONFIG, KIND_SET_EDGE, 16'd0, 1'b0, 32'd0, 32'd0, 32'd0, 32'hFFFF_FFF8},
    '{ROW_WORD, KIND_READ, 16'd0, 1'b0, 32'd0, 32'd0, 32'd0, 32'd0},
    '{ROW_WORD, KIND_RESTART, 16'd0, 1'b0, 32'd0, 32'd0, 32'd0, 32'd0},
    '{ROW_WORD, KIND_READ, 16'd0, 1'b1, 32'd0, 32'd0, 32'd0, 32'd0}
  };

  // Rounds a Q30 value half up to Q1.14 and clips it to plus or minus one.
  function automatic int round_q14(input longint v);
    longint r;
    r = (v + 64'sd32768) >>> 16;
    if (r > 64'sd16384) r = 64'sd16384;
    if (r < -64'sd16384) r = -64'sd16384;
    return int'(r);
  endfunction

  // Cosine and sine of a phase, taken at the table grid: the angle within its quadrant is
  // rotated by an integer CORDIC, and the quadrant is then folded back in.
  function automatic void table_cos_sin(input bit [31:0] phase, output int c, output int s);
    bit [31:0] ang;
    longint    x;
    longint    y;
    longint    z;
    longint    xs;
    longint    ys;
    int        cq;
    int        sq;
    int        i;
    ang = (phase >> (32 - SINE_TABLE_BITS)) << (32 - SINE_TABLE_BITS);
    x = ROTATION_GAIN_Q30;
    y = 0;
    z = longint'(ang[29:0]);
    for (i = 0; i < ROTATION_STEPS; i++) begin
      xs = y >>> i;
      ys = x >>> i;
      if (z >= 0) begin
        x = x - xs;
        y = y + ys;
        z = z - ARC_STEP[i];
      end else begin
        x = x + xs;
        y = y - ys;
        z = z + ARC_STEP[i];
      end
    end
    cq = round_q14(x);
    sq = round_q14(y);
    case (ang[31:30])
      2'd0: begin
        c = cq;
        s = sq;
      end
      2'd1: begin
        c = -sq;
        s = cq;
      end
      2'd2: begin
        c = -cq;
        s = -sq;
      end
      default: begin
        c = sq;
        s = -cq;
      end
    endcase
  endfunction

  function automatic int sat_sum(input int a, input int b);
    longint r;
    r = longint'(a) + longint'(b);
    if (r > 64'sd2147483647) r = 64'sd2147483647;
    if (r < -64'sd2147483648) r = -64'sd2147483648;
    return int'(r);
  endfunction

  // Squared magnitude of a band's sums, scaled down by 2^28 and saturated to 32 bits.
  function automatic bit [31:0] band_power(input int re, input int im);
    bit [63:0] ure;
    bit [63:0] uim;
    bit [63:0] pw;
    ure = (re < 0) ? -longint'(re) : longint'(re);
    uim = (im < 0) ? -longint'(im) : longint'(im);
    pw = (ure * ure + uim * uim) >> 28;
    return (pw > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : pw[31:0];
  endfunction

  // Applies one accepted pulse word to the expected band state and queues the scores that a
  // read produces. A typed-in score, where given, stands for every band of the read.
  function automatic void apply_pulse_word(input kind_t kind, input bit [15:0] length,
                                           input bit known, input bit [31:0] known_score);
    int          hs;
    int          bands;
    int          i;
    longint      offset;
    bit [31:0]   step;
    int          c;
    int          s;
    band_score_t r;
    hs = (span_q > MAX_HALF_SPAN) ? MAX_HALF_SPAN : int'(span_q);
    bands = 2 * hs + 1;
    case (kind)
      KIND_RESTART: begin
        for (i = 0; i < BAND_SLOTS; i++) begin
          phase_acc[i] = '0;
          re_acc[i] = 0;
          im_acc[i] = 0;
        end
      end
      KIND_READ: begin
        for (i = 0; i < bands; i++) begin
          r.band_index = 4'(i);
          r.score = known ? known_score : band_power(re_acc[i], im_acc[i]);
          r.last = (i == bands - 1);
          expected_scores.push_back(r);
        end
      end
      default: begin
        for (i = 0; i < bands; i++) begin
          offset = longint'(i - hs) * longint'(spacing_q);
          step = root_step_q + offset[31:0];
          phase_acc[i] = phase_acc[i] + step * {16'd0, length};
          if (kind == KIND_SET_EDGE) begin
            table_cos_sin(phase_acc[i], c, s);
            re_acc[i] = sat_sum(re_acc[i], c);
            im_acc[i] = sat_sum(im_acc[i], s);
          end
        end
      end
    endcase
  endfunction

  // Offers one pulse word, after a random number of idle cycles, and holds it until the
  // bank takes it. Called and returns at a falling edge. Valid is left high so that a word
  // that follows at once goes out without a bubble.
  task automatic send_word(input kind_t kind, input bit [15:0] length,
                           input bit known = 1'b0, input bit [31:0] known_score = '0);
    while ($urandom_range(99) < idle_pct) begin
      pulses.valid <= 1'b0;
      @(negedge clk);
    end
    pulses.valid <= 1'b1;
    pulses.kind <= kind;
    pulses.length <= length;
    @(posedge clk);
    while (!pulses.ready) @(posedge clk);
    apply_pulse_word(kind, length, known, known_score);
    @(negedge clk);
  endtask

  // Waits until the bank is idle, then writes all three registers plus the unused index.
  task automatic configure(input bit [31:0] root, input bit [31:0] spacing,
                           input bit [31:0] span);
    logic [1:0] order [4];
    bit [31:0]  value [4];
    int         k;
    order = '{REG_ROOT_STEP, REG_BAND_SPACING, REG_HALF_SPAN, REG_UNUSED};
    value = '{root, spacing, span, $urandom()};
    pulses.valid <= 1'b0;
    while (expected_scores.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    for (k = 0; k < 4; k++) begin
      wr_en <= 1'b1;
      wr_index <= order[k];
      wr_data <= value[k];
      @(posedge clk);
      case (order[k])
        REG_ROOT_STEP:    root_step_q = value[k];
        REG_BAND_SPACING: spacing_q = value[k];
        REG_HALF_SPAN:    span_q = value[k][2:0];
        default:          ;
      endcase
      @(negedge clk);
    end
    wr_en <= 1'b0;
  endtask

  // The score consumer stalls at random, at the same rate as the pulse source idles.
  always @(negedge clk) begin
    scores.ready <= ($urandom_range(99) >= idle_pct);
  end

  // Every score word taken is compared field by field with the oldest expectation.
  always @(posedge clk) begin : score_check
    band_score_t want;
    if (!rst && scores.valid && scores.ready) begin
      if (expected_scores.size() == 0) begin
        $error("unexpected score word: band_index %0d score %0h last %0b",
               scores.band_index, scores.score, scores.last);
        errors++;
      end else begin
        want = expected_scores.pop_front();
        if (scores.band_index !== want.band_index) begin
          $error("band_index mismatch: expected %0d, actual %0d",
                 want.band_index, scores.band_index);
          errors++;
        end
        if (scores.score !== want.score) begin
          $error("score mismatch: expected %0h, actual %0h", want.score, scores.score);
          errors++;
        end
        if (scores.last !== want.last) begin
          $error("last mismatch: expected %0b, actual %0b", want.last, scores.last);
          errors++;
        end
      end
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("pulse_timing_dft_band_bank test failed");
    $finish;
  end

  initial begin : stimulus
    plan_row_t   row;
    kind_t       kind;
    bit [15:0]   length;
    bit [31:0]   root;
    bit [31:0]   spacing;
    bit [31:0]   span;
    int          n;
    int          p;
    int          w;
    int          pick;

    rst = 1'b1;
    wr_en = 1'b0;
    wr_index = REG_ROOT_STEP;
    wr_data = '0;
    pulses.valid = 1'b0;
    pulses.kind = KIND_SET_EDGE;
    pulses.length = '0;
    errors = 0;
    idle_pct = IDLE_PERCENT;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part: extremes of every field, every kind of word, and the special cases.
    for (n = 0; n < 25; n++) begin
      row = directed_plan[n];
      if (row.what == ROW_CONFIG) begin
        configure(row.root, row.spacing, row.span);
      end else begin
        send_word(row.kind, row.length, row.known, row.score);
      end
    end

    // Random part: several register settings, each followed by a stream of edges with the
    // occasional read and restart. The first two settings pin the half span to its
    // extremes; the upper bits of the half span word are random to show they are ignored.
    // One phase runs with no idling on either side.
    for (p = 0; p < RANDOM_PHASES; p++) begin
      case ($urandom_range(3))
        0:       root = 32'd0;
        1:       root = 32'hFFFF_FFFF;
        2:       root = $urandom_range(255);
        default: root = $urandom();
      endcase
      case ($urandom_range(3))
        0:       spacing = 32'h8000_0000;
        1:       spacing = 32'h7FFF_FFFF;
        2:       spacing = 32'($urandom_range(512)) - 32'd256;
        default: spacing = $urandom();
      endcase
      if (p == 0) span = 32'hFFFF_FFFF;
      else if (p == 1) span = 32'd0;
      else span = $urandom();
      configure(root, spacing, span);
      idle_pct = (p == BUSY_PHASE) ? 0 : IDLE_PERCENT;

      for (w = 0; w < WORDS_PER_PHASE; w++) begin
        pick = $urandom_range(99);
        if (w == WORDS_PER_PHASE - 1) kind = KIND_READ;
        else if (pick < 45) kind = KIND_SET_EDGE;
        else if (pick < 75) kind = KIND_RESET_EDGE;
        else if (pick < 93) kind = KIND_READ;
        else kind = KIND_RESTART;
        case ($urandom_range(9))
          0:       length = 16'd0;
          1:       length = 16'hFFFF;
          2, 3, 4: length = 16'($urandom_range(64));
          default: length = 16'($urandom());
        endcase
        send_word(kind, length);
      end
    end
    idle_pct = IDLE_PERCENT;

    // Drain: wait for the last scores, then give the bank time to show any stray word.
    pulses.valid <= 1'b0;
    while (expected_scores.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (errors == 0) begin
      $display("pulse_timing_dft_band_bank test passed");
    end else begin
      $display("pulse_timing_dft_band_bank test failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
design/ptdbb_pkg.sv
design/ptdbb_if.sv
design/pulse_timing_dft_band_bank.sv
design/ptdbb_checker.sv
dv/testbench.sv
